### rtl/reliable_in_order_reorder_buffer_defines.svh
// Assertion macros for the reorder buffer top level.
// Both macros expect signals named clock and reset in the scope of use.
`ifndef RELIABLE_IN_ORDER_REORDER_BUFFER_DEFINES_SVH
`define RELIABLE_IN_ORDER_REORDER_BUFFER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RORB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RORB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rorb_pkg.sv
// Shared types and constants of the reorder buffer.
// No dependencies; used by every module of the block except rorb_ram.
package rorb_pkg;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   // Register select is the word address bit; byte lane bits are ignored.
   localparam logic [CSR_ADDR_W-1:0] CSR_CLOSING_MODE_ADDR = 3'd0;

   typedef enum logic [2:0] {
      STATUS_DELIVERED = 3'd0,
      STATUS_BUFFERED  = 3'd1,
      STATUS_DUPLICATE = 3'd2,
      STATUS_BEYOND    = 3'd3,
      STATUS_CLOSED    = 3'd4
   } status_type;

   typedef struct packed {
      logic        is_reliable;
      logic [31:0] seq_number;
      logic        is_close;
      logic [15:0] payload_tag;
   } req_word_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] out_tag;
      logic        deliver;
      logic        out_close;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] tag;
      logic        close;
   } slot_word_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DECIDE,
      BACK_CHECK,
      BACK_FINAL
   } back_state_type;

   typedef struct packed {
      logic closed;
      logic idle;
   } back_status_type;

endpackage

### rtl/rorb_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module rorb_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rorb_front.sv
// Intake side: accepts request words and holds them in a short queue.
// Depends on rorb_pkg.
module rorb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rorb_pkg::req_word_type req_data,
   input  logic                  pop,
   output logic                  avail,
   output rorb_pkg::req_word_type head
);

   localparam int PW = (rorb_pkg::QUEUE_DEPTH > 1) ? $clog2(rorb_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(rorb_pkg::QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(rorb_pkg::QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(rorb_pkg::QUEUE_DEPTH);

   rorb_pkg::req_word_type entry_ff [rorb_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push;
   logic          take;

   assign req_stall = (count_ff == FULL_CNT);
   assign avail     = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign take      = pop && avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

### rtl/rorb_back.sv
// Sequencing engine: classifies queued words against the expected sequence,
// buffers early words in the slot RAM and drains in-order successors.
// Depends on rorb_pkg and rorb_ram.
module rorb_back #(
   parameter int WINDOW = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      closing_mode,
   input  logic                      avail,
   input  rorb_pkg::req_word_type    head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rorb_pkg::rsp_word_type    rsp_data,
   output rorb_pkg::back_status_type status
);

   localparam int IW = $clog2(WINDOW);
   localparam int CW = $clog2(WINDOW + 1);
   localparam int SW = $bits(rorb_pkg::slot_word_type);
   localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);
   localparam logic [IW:0]   WIN_SUM  = (IW + 1)'(WINDOW);
   localparam logic [CW-1:0] CNT_MAX  = CW'(WINDOW);

   rorb_pkg::back_state_type state_ff, state_in;
   logic [31:0]            exp_ff, exp_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [WINDOW-1:0]      valid_ff, valid_in;
   logic                   closed_ff, closed_in;
   rorb_pkg::req_word_type item_ff, item_in;
   logic                   lt_ff, lt_in;
   logic                   eq_ff, eq_in;
   logic                   far_ff, far_in;
   logic [IW-1:0]          delta_ff, delta_in;
   logic [15:0]            pend_tag_ff, pend_tag_in;
   logic                   pend_close_ff, pend_close_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rorb_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [31:0]            diff;
   logic [31:0]            exp_inc;
   logic [IW-1:0]          idx_inc;
   logic [IW:0]            sum;
   logic [IW:0]            sum_wrap;
   logic [IW-1:0]          bidx;
   logic                   out_free;
   logic                   hit;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   rorb_pkg::slot_word_type slot_wr;
   rorb_pkg::slot_word_type slot_rd;
   logic [SW-1:0]          slot_rd_bits;

   rorb_ram #(
      .WIDTH(SW),
      .DEPTH(WINDOW)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(bidx),
      .wr_data(slot_wr),
      .rd_en  (ram_rd_en),
      .rd_addr(idx_in),
      .rd_data(slot_rd_bits)
   );

   assign slot_rd = rorb_pkg::slot_word_type'(slot_rd_bits);
   assign slot_wr = '{seq: item_ff.seq_number, tag: item_ff.payload_tag,
                      close: item_ff.is_close};

   assign diff    = head.seq_number - exp_ff;
   assign exp_inc = exp_ff + 32'd1;
   // The slot index follows expected_seq modulo the window; at the 32-bit
   // wrap the sequence restarts at zero and so does the index.
   assign idx_inc = (exp_ff == '1) ? '0 : ((idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1);

   // Early words are at most one window ahead, so one subtract reduces the index.
   assign sum      = {1'b0, idx_ff} + {1'b0, delta_ff};
   assign sum_wrap = sum - WIN_SUM;
   assign bidx     = (sum >= WIN_SUM) ? sum_wrap[IW-1:0] : sum[IW-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign hit      = valid_ff[idx_ff] && (slot_rd.seq == exp_ff) && (cnt_ff < CNT_MAX);

   always_comb begin
      state_in      = state_ff;
      exp_in        = exp_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      closed_in     = closed_ff;
      item_in       = item_ff;
      lt_in         = lt_ff;
      eq_in         = eq_ff;
      far_in        = far_ff;
      delta_in      = delta_ff;
      pend_tag_in   = pend_tag_ff;
      pend_close_in = pend_close_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      case (state_ff)
         rorb_pkg::BACK_IDLE: begin
            if (avail) begin
               pop      = 1'b1;
               item_in  = head;
               lt_in    = head.seq_number < exp_ff;
               eq_in    = head.seq_number == exp_ff;
               far_in   = diff >= 32'(WINDOW);
               delta_in = diff[IW-1:0];
               state_in = rorb_pkg::BACK_DECIDE;
            end
         end

         rorb_pkg::BACK_DECIDE: begin
            if (out_free) begin
               rsp_in.out_tag   = item_ff.payload_tag;
               rsp_in.deliver   = 1'b0;
               rsp_in.out_close = 1'b0;
               rsp_in.last      = 1'b1;
               state_in         = rorb_pkg::BACK_IDLE;
               if (closed_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = rorb_pkg::STATUS_CLOSED;
               end else if (item_ff.is_reliable && lt_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = rorb_pkg::STATUS_DUPLICATE;
               end else if (item_ff.is_reliable && !eq_ff) begin
                  rsp_valid_in = 1'b1;
                  if (far_ff) begin
                     rsp_in.status = rorb_pkg::STATUS_BEYOND;
                  end else if (valid_ff[bidx]) begin
                     rsp_in.status = rorb_pkg::STATUS_DUPLICATE;
                  end else begin
                     rsp_in.status  = rorb_pkg::STATUS_BUFFERED;
                     ram_wr_en      = 1'b1;
                     valid_in[bidx] = 1'b1;
                  end
               end else begin
                  // The word itself is delivered; its result waits until
                  // the next slot shows whether it is the last one.
                  pend_tag_in   = item_ff.payload_tag;
                  pend_close_in = item_ff.is_close;
                  cnt_in        = CW'(1);
                  if (item_ff.is_reliable) begin
                     exp_in = exp_inc;
                     idx_in = idx_inc;
                  end
                  if (item_ff.is_close) begin
                     state_in = rorb_pkg::BACK_FINAL;
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in  = rorb_pkg::BACK_CHECK;
                  end
               end
            end
         end

         rorb_pkg::BACK_CHECK: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = rorb_pkg::STATUS_DELIVERED;
               rsp_in.out_tag   = pend_tag_ff;
               rsp_in.deliver   = !closing_mode;
               rsp_in.out_close = pend_close_ff;
               if (hit) begin
                  rsp_in.last      = 1'b0;
                  pend_tag_in      = slot_rd.tag;
                  pend_close_in    = slot_rd.close;
                  valid_in[idx_ff] = 1'b0;
                  exp_in           = exp_inc;
                  idx_in           = idx_inc;
                  cnt_in           = cnt_ff + CW'(1);
                  if (slot_rd.close) begin
                     state_in = rorb_pkg::BACK_FINAL;
                  end else begin
                     ram_rd_en = 1'b1;
                  end
               end else begin
                  rsp_in.last = 1'b1;
                  state_in    = rorb_pkg::BACK_IDLE;
               end
            end
         end

         rorb_pkg::BACK_FINAL: begin
            // Only a close word ends up here: it shuts the channel for good.
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = rorb_pkg::STATUS_DELIVERED;
               rsp_in.out_tag   = pend_tag_ff;
               rsp_in.deliver   = !closing_mode;
               rsp_in.out_close = pend_close_ff;
               rsp_in.last      = 1'b1;
               closed_in        = 1'b1;
               valid_in         = '0;
               state_in         = rorb_pkg::BACK_IDLE;
            end
         end

         default: begin
            state_in = rorb_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rorb_pkg::BACK_IDLE;
         exp_ff       <= '0;
         idx_ff       <= '0;
         valid_ff     <= '0;
         closed_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         closed_ff    <= closed_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      lt_ff         <= lt_in;
      eq_ff         <= eq_in;
      far_ff        <= far_in;
      delta_ff      <= delta_in;
      pend_tag_ff   <= pend_tag_in;
      pend_close_ff <= pend_close_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign status.closed = closed_ff;
   assign status.idle   = (state_ff == rorb_pkg::BACK_IDLE);

endmodule

### rtl/reliable_in_order_reorder_buffer.sv
// Reorder buffer: a two-word intake queue feeds a sequencing engine that pops
// a word in its idle state and classifies it in its decide state; a delivered
// word then passes through the check state, which also drains each in-order
// successor, or the final state for a close word. Results are registered into the
// output register, unless a stall holds them. Synchronous reset clears control
// state, slot valid flags included, at once; no clearing pass follows.
module reliable_in_order_reorder_buffer #(
   parameter int WINDOW = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rorb_pkg::req_word_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rorb_pkg::rsp_word_type                rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [rorb_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [rorb_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [rorb_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

`include "reliable_in_order_reorder_buffer_defines.svh"

   logic                      closing_mode_ff, closing_mode_in;
   logic                      sel_closing_mode;
   logic                      pop;
   logic                      avail;
   rorb_pkg::req_word_type    head;
   rorb_pkg::back_status_type status;
   logic                      rsp_delivered;
   logic                      rsp_open_delivery;

   assign pready = 1'b1;
   assign sel_closing_mode = (paddr[rorb_pkg::CSR_ADDR_W-1:2] ==
                              rorb_pkg::CSR_CLOSING_MODE_ADDR[rorb_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      closing_mode_in = closing_mode_ff;
      if (psel && penable && pwrite && pready && sel_closing_mode) begin
         closing_mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         closing_mode_ff <= 1'b0;
      end else begin
         closing_mode_ff <= closing_mode_in;
      end
   end

   assign prdata = sel_closing_mode ? {{(rorb_pkg::CSR_DATA_W - 1){1'b0}}, closing_mode_ff}
                                    : '0;

   rorb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .pop      (pop),
      .avail    (avail),
      .head     (head)
   );

   rorb_back #(
      .WINDOW(WINDOW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .closing_mode(closing_mode_ff),
      .avail       (avail),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .status      (status)
   );

   assign rsp_delivered     = rsp_valid && (rsp_data.status == rorb_pkg::STATUS_DELIVERED);
   assign rsp_open_delivery = rsp_delivered && !rsp_data.out_close;

   // Only a delivered word can be followed by drained successors.
   `RORB_ASSERT_SAME(a_single_is_last, rsp_valid && !rsp_delivered, rsp_data.last, "not last")
   // A word that is not last means the drain is still in progress.
   `RORB_ASSERT_SAME(a_drain_busy, rsp_valid && !rsp_data.last, !status.idle, "idle mid drain")
   // Nothing is delivered after the channel closed, except the close word.
   `RORB_ASSERT_SAME(a_no_deliver_closed, rsp_open_delivery, !status.closed, "delivery after close")
   // A closed channel stays closed until reset.
   `RORB_ASSERT_NEXT(a_closed_sticks, status.closed, status.closed, "closed flag dropped")

endmodule
